// File: src/bmid_pkg.sv
package bmid_pkg;

  // Table geometry: the bitmap is split over a row of equal cells.
  localparam int TABLE_SIZE = 256;
  localparam int CELL_BITS  = 16;
  localparam int NUM_CELLS  = TABLE_SIZE / CELL_BITS;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int BIT_W      = $clog2(CELL_BITS);
  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int COUNT_W    = IDX_W + 1;

  localparam logic [31:0] TAG_STEP = 32'(TABLE_SIZE);

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_TOP_MASK = 1'b0,
    REG_RESERVED = 1'b1
  } reg_idx_t;

  // Broadcast operation to every cell.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_FREE = 2'd1,
    OP_INIT = 2'd2
  } cell_op_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] handle_in;
  } command_t;

  typedef struct packed {
    logic [31:0] handle_out;
    logic        failed;
  } result_t;

  // Control broadcast from the sequencer to the cells.
  typedef struct packed {
    cell_op_t             op;
    logic [IDX_W-1:0]     free_idx;
    logic [COUNT_W-1:0]   init_count;
    logic [IDX_W-1:0]     scan_from;
  } cell_ctrl_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } token_t;

endpackage

// File: src/bitmap_id_allocator_rotating_tag_top.sv
// Channel     Ports                                 Transfer
// command     start, busy, command                  start high while busy low
// result      done, result                          done high for one cycle
// config      psel, penable, pwrite, paddr, pwdata,  psel, penable, pwrite high
//             prdata, pready
//
// An allocation sends a search token down a row of 16 cells of 16 bits each,
// one cell per cycle: the result appears after the token leaves the row, and busy
// drops with it. When the first pass starts past entry zero and finds nothing,
// a second pass from zero follows. Free, init and unused commands give
// their result in the cycle after the command. Reset (rst, synchronous)
// clears the bitmap, the tag and the search start at once.
// The receiver cannot stall: each result is valid for exactly one cycle.
module bitmap_id_allocator_rotating_tag_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  bmid_pkg::command_t   command,
  output logic                 done,
  output bmid_pkg::result_t    result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                               state;
  logic [31:0]                          top_mask;
  logic [bmid_pkg::COUNT_W-1:0]         reserved_count;
  logic [bmid_pkg::IDX_W-1:0]           search_start;
  logic [31:0]                          rotor_tag;
  logic                                 launch;
  logic                                 second_pass;
  logic [bmid_pkg::IDX_W-1:0]           scan_from;
  logic                                 accept;
  logic                                 cfg_write;
  logic [bmid_pkg::IDX_W-1:0]           free_idx;
  bmid_pkg::cell_ctrl_t                 ctrl;
  bmid_pkg::token_t                     tok [0:bmid_pkg::NUM_CELLS];
  logic [bmid_pkg::NUM_CELLS:0]         tok_valid;
  bmid_pkg::token_t                     last_tok;

  assign accept    = start && !busy;
  assign busy      = (state == S_SCAN);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign free_idx  = command.handle_in[bmid_pkg::IDX_W-1:0];
  assign last_tok  = tok[bmid_pkg::NUM_CELLS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_mask       <= '1;
      reserved_count <= '0;
    end else if (cfg_write) begin
      unique case (bmid_pkg::reg_idx_t'(paddr[2]))
        bmid_pkg::REG_TOP_MASK: top_mask <= pwdata;
        bmid_pkg::REG_RESERVED: reserved_count <= pwdata[bmid_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bmid_pkg::reg_idx_t'(paddr[2]))
      bmid_pkg::REG_TOP_MASK: prdata = top_mask;
      bmid_pkg::REG_RESERVED: prdata = {{(32 - bmid_pkg::COUNT_W){1'b0}}, reserved_count};
      default:                prdata = top_mask;
    endcase
  end

  // Broadcast to the cells: free and init act at the command's transfer.
  always_comb begin
    ctrl.op         = bmid_pkg::OP_NONE;
    ctrl.free_idx   = free_idx;
    ctrl.init_count = reserved_count;
    ctrl.scan_from  = scan_from;
    if (accept && command.cmd == bmid_pkg::CMD_FREE) begin
      ctrl.op = bmid_pkg::OP_FREE;
    end else if (accept && command.cmd == bmid_pkg::CMD_INIT) begin
      ctrl.op = bmid_pkg::OP_INIT;
    end
  end

  // The token enters the first cell while launch is high.
  assign tok[0] = '{valid: launch, found: 1'b0, idx: '0};

  for (genvar k = 0; k < bmid_pkg::NUM_CELLS; k++) begin : g_cell
    bmid_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (bmid_pkg::CELL_W'(k)),
      .ctrl    (ctrl),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= bmid_pkg::NUM_CELLS; k++) begin
      tok_valid[k] = tok[k].valid;
    end
  end

  // Sequencer: runs the scan passes and forms the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch       <= 1'b0;
      done         <= 1'b0;
      search_start <= '0;
      rotor_tag    <= '0;
      second_pass  <= 1'b0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (command.cmd)
              bmid_pkg::CMD_ALLOC: begin
                state       <= S_SCAN;
                launch      <= 1'b1;
                second_pass <= 1'b0;
              end
              bmid_pkg::CMD_FREE: begin
                done      <= 1'b1;
                rotor_tag <= (rotor_tag + bmid_pkg::TAG_STEP) & top_mask;
                if (free_idx < search_start) begin
                  search_start <= free_idx;
                end
              end
              bmid_pkg::CMD_INIT: begin
                done         <= 1'b1;
                search_start <= '0;
                rotor_tag    <= '0;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (last_tok.valid) begin
            if (last_tok.found) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              // The first miss always advances the tag.
              if (!second_pass) begin
                rotor_tag <= (rotor_tag + bmid_pkg::TAG_STEP) & top_mask;
              end
              if (!second_pass && scan_from != '0) begin
                second_pass <= 1'b1;
                launch      <= 1'b1;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Search start of the pass that is launched next.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      scan_from <= search_start;
    end else if (last_tok.valid) begin
      scan_from <= '0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      if (last_tok.found) begin
        result.handle_out <= {{(32 - bmid_pkg::IDX_W){1'b0}}, last_tok.idx} | rotor_tag;
        result.failed     <= 1'b0;
      end else begin
        result.handle_out <= '1;
        result.failed     <= 1'b1;
      end
    end else begin
      result.handle_out <= '0;
      result.failed     <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // Only one search token is ever in flight along the row.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one search token in the cell row");

  // A token leaves the row only while a scan is running.
  a_tok_in_scan: assert property (@(posedge clk) disable iff (rst)
    last_tok.valid |-> state == S_SCAN)
    else $error("search token outside a scan");

  // A failed allocation reports all ones.
  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.failed) |-> result.handle_out == '1)
    else $error("failed allocation with a wrong handle");

  // Every launch happens inside a scan.
  a_launch_scan: assert property (@(posedge clk) disable iff (rst)
    launch |-> state == S_SCAN)
    else $error("token launched while idle");
`endif

endmodule

// File: src/bmid_cell.sv
module bmid_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bmid_pkg::CELL_W-1:0]   cell_id,
  input  bmid_pkg::cell_ctrl_t          ctrl,
  input  bmid_pkg::token_t              tok_in,
  output bmid_pkg::token_t              tok_out
);

  logic [bmid_pkg::CELL_BITS-1:0] used;
  logic [bmid_pkg::CELL_BITS-1:0] cand;
  logic [bmid_pkg::CELL_BITS-1:0] init_word;
  logic [bmid_pkg::BIT_W-1:0]     enc;
  logic                           any_free;
  logic                           claim;
  logic                           free_hit;

  // Free entries of this cell that lie at or after the search start.
  always_comb begin
    for (int j = 0; j < bmid_pkg::CELL_BITS; j++) begin
      cand[j] = !used[j] &&
                ({cell_id, bmid_pkg::BIT_W'(j)} >= ctrl.scan_from);
      init_word[j] = {1'b0, cell_id, bmid_pkg::BIT_W'(j)} < ctrl.init_count;
    end
  end

  // Lowest candidate wins.
  always_comb begin
    enc = '0;
    for (int j = bmid_pkg::CELL_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        enc = bmid_pkg::BIT_W'(j);
      end
    end
  end

  assign any_free = |cand;
  assign claim    = tok_in.valid && !tok_in.found && any_free;
  assign free_hit = (ctrl.op == bmid_pkg::OP_FREE) &&
                    (ctrl.free_idx[bmid_pkg::IDX_W-1:bmid_pkg::BIT_W] == cell_id);

  // Bitmap slice held by this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctrl.op == bmid_pkg::OP_INIT) begin
      used <= init_word;
    end else if (free_hit) begin
      used[ctrl.free_idx[bmid_pkg::BIT_W-1:0]] <= 1'b0;
    end else if (claim) begin
      used[enc] <= 1'b1;
    end
  end

  // Hand the token on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (claim) begin
      tok_out.found <= 1'b1;
      tok_out.idx   <= {cell_id, enc};
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.idx   <= tok_in.idx;
    end
  end

endmodule
